>>> design/mprf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mprf_pkg;

    localparam int TOPIC_W   = 40;
    localparam int HDR_W     = 48;
    localparam int HDR_BYTES = 6;
    localparam int CRC_END   = 8;
    localparam int HASH_END  = 10;
    localparam int ADDR_W    = 6;

    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [7:0]  LEN_MAX   = 8'd255;
    localparam logic [5:0]  NET_BITS_MAX = 6'd40;

    localparam logic [2:0] KIND_SHORT   = 3'd0;
    localparam logic [2:0] KIND_BAD_CRC = 3'd1;
    localparam logic [2:0] KIND_FOREIGN = 3'd2;
    localparam logic [2:0] KIND_ACCEPT  = 3'd3;
    localparam logic [2:0] KIND_CLEAR   = 3'd4;

    localparam logic [2:0] REG_HASH_SALT    = 3'd0;
    localparam logic [2:0] REG_NETWORK_ID   = 3'd1;
    localparam logic [2:0] REG_NETWORK_BITS = 3'd2;
    localparam logic [2:0] REG_HELP_TOPIC   = 3'd3;
    localparam logic [2:0] REG_REBROADCAST  = 3'd4;

    typedef struct packed {
        logic [31:0] hash_salt;
        logic [39:0] network_id;
        logic [5:0]  network_bits;
        logic [39:0] help_topic;
        logic        rebroadcast;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [39:0] topic;
        logic [7:0]  payload_len;
        logic [7:0]  seq_gap;
        logic        relay;
        logic        duplicate;
        logic        dup_overflow;
    } result_t;

    typedef struct packed {
        logic take_byte;
        logic take_last;
        logic take_tick;
        logic clr_en;
        logic chk_en;
        logic trk_rd;
        logic trk_cmp;
        logic trk_upd;
        logic mod_en;
        logic bm_rd;
        logic bm_upd;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_short;
        logic crc_ok;
        logic foreign;
        logic help;
        logic relay_on;
        logic trk_match;
        logic trk_last;
        logic mod_last;
    } status_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [31:0] hash_byte(input logic [31:0] h, input logic [7:0] b);
        logic [63:0] p;
        p = 64'(h ^ {24'h000000, b}) * 64'(FNV_PRIME);
        return p[31:0];
    endfunction

endpackage
`default_nettype wire

>>> design/mprf_intf.sv
`timescale 1ns / 1ps
`default_nettype none
interface mprf_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, cmd, data_byte, last_byte, input ready);
    modport sink (input valid, cmd, data_byte, last_byte, output ready);
endinterface

interface mprf_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [39:0] topic;
    logic [7:0]  payload_len;
    logic [7:0]  seq_gap;
    logic        relay;
    logic        duplicate;
    logic        dup_overflow;
    modport source (output valid, kind, topic, payload_len, seq_gap, relay, duplicate,
                    dup_overflow, input ready);
    modport sink (input valid, kind, topic, payload_len, seq_gap, relay, duplicate,
                  dup_overflow, output ready);
endinterface
`default_nettype wire

>>> design/mesh_packet_rx_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Role    Protocol         Payload
// in_ch     sink    valid/ready      cmd, data_byte, last_byte
// out_ch    source  valid/ready      kind, topic, payload_len, seq_gap, relay,
//                                    duplicate, dup_overflow
// cfg       slave   APB, pready=1    hash_salt, network_id, network_bits,
//                                    help_topic, rebroadcast at 8*i
// After a packet byte that is not the last, in_ch stays ready for the next byte.
// After the last byte in_ch is not ready while the block checks length, CRC and network,
// scans and updates the topic table when an accepted topic is not the help topic, and,
// when relay is enabled, computes the hash index and reads and updates the bitmap.
// Reset and each clear tick sweep every bitmap entry with in_ch not ready; a clear tick
// then issues a clear verdict that also reports dup_overflow.
// One finished transaction waits in the output register while bytes keep arriving;
// the next verdict stalls until that register is free.
module mesh_packet_rx_filter #(
    parameter int SEQ_TRACKS     = 8,
    parameter int HASH_SIZE      = 1024,
    parameter int MAX_DATA_BYTES = 256
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    mprf_in_if.sink                          in_ch,
    mprf_out_if.source                       out_ch,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mprf_pkg::ADDR_W-1:0] paddr,
    input  wire logic [63:0]                 pwdata,
    output logic [63:0]                      prdata,
    output logic                             pready
);
    mprf_pkg::cfg_t    cfg;
    mprf_pkg::cmd_t    cmd;
    mprf_pkg::status_t st;
    mprf_pkg::result_t res;

    mprf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mprf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_cmd    (in_ch.cmd),
        .in_last   (in_ch.last_byte),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .st        (st),
        .cmd       (cmd)
    );

    mprf_dp #(
        .SEQ_TRACKS     (SEQ_TRACKS),
        .HASH_SIZE      (HASH_SIZE),
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (in_ch.data_byte),
        .cfg       (cfg),
        .cmd       (cmd),
        .st        (st),
        .out_res   (res)
    );

    assign out_ch.kind         = res.kind;
    assign out_ch.topic        = res.topic;
    assign out_ch.payload_len  = res.payload_len;
    assign out_ch.seq_gap      = res.seq_gap;
    assign out_ch.relay        = res.relay;
    assign out_ch.duplicate    = res.duplicate;
    assign out_ch.dup_overflow = res.dup_overflow;
endmodule
`default_nettype wire

>>> design/mprf_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module mprf_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [mprf_pkg::ADDR_W-1:0] paddr,
    input  wire logic [63:0]                pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready,
    output mprf_pkg::cfg_t                  cfg
);
    mprf_pkg::cfg_t cfg_reg;
    logic [2:0]     idx;

    assign idx    = paddr[mprf_pkg::ADDR_W-1:3];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                mprf_pkg::REG_HASH_SALT:    cfg_reg.hash_salt    <= pwdata[31:0];
                mprf_pkg::REG_NETWORK_ID:   cfg_reg.network_id   <= pwdata[39:0];
                mprf_pkg::REG_NETWORK_BITS: cfg_reg.network_bits <= pwdata[5:0];
                mprf_pkg::REG_HELP_TOPIC:   cfg_reg.help_topic   <= pwdata[39:0];
                mprf_pkg::REG_REBROADCAST:  cfg_reg.rebroadcast  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            mprf_pkg::REG_HASH_SALT:    prdata = {32'h0, cfg_reg.hash_salt};
            mprf_pkg::REG_NETWORK_ID:   prdata = {24'h0, cfg_reg.network_id};
            mprf_pkg::REG_NETWORK_BITS: prdata = {58'h0, cfg_reg.network_bits};
            mprf_pkg::REG_HELP_TOPIC:   prdata = {24'h0, cfg_reg.help_topic};
            mprf_pkg::REG_REBROADCAST:  prdata = {63'h0, cfg_reg.rebroadcast};
            default:                    prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

>>> design/mprf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mprf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_cmd,
    input  wire logic              in_last,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire mprf_pkg::status_t st,
    output mprf_pkg::cmd_t         cmd
);
    typedef enum logic [9:0] {
        S_CLR  = 10'b0000000001,
        S_IDLE = 10'b0000000010,
        S_CHK  = 10'b0000000100,
        S_TRD  = 10'b0000001000,
        S_TCMP = 10'b0000010000,
        S_TUPD = 10'b0000100000,
        S_MOD  = 10'b0001000000,
        S_BRD  = 10'b0010000000,
        S_BUPD = 10'b0100000000,
        S_DONE = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   tick_reg, tick_next;
    logic   out_valid_reg, out_valid_next;
    logic   acc;

    assign in_ready  = (state_reg == S_IDLE);
    assign acc       = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        tick_next      = tick_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr_en = 1'b1;
                if (st.clr_last)
                begin
                    state_next = tick_reg ? S_DONE : S_IDLE;
                    tick_next  = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (acc)
                begin
                    if (in_cmd)
                    begin
                        cmd.take_tick = 1'b1;
                        tick_next     = 1'b1;
                        state_next    = S_CLR;
                    end
                    else
                    begin
                        cmd.take_byte = 1'b1;
                        cmd.take_last = in_last;
                        if (in_last)
                        begin
                            state_next = S_CHK;
                        end
                    end
                end
            end
            S_CHK:
            begin
                cmd.chk_en = !st.is_short;
                if (st.is_short || !st.crc_ok || st.foreign)
                begin
                    state_next = S_DONE;
                end
                else if (!st.help)
                begin
                    state_next = S_TRD;
                end
                else
                begin
                    state_next = st.relay_on ? S_MOD : S_DONE;
                end
            end
            S_TRD:
            begin
                cmd.trk_rd = 1'b1;
                state_next = S_TCMP;
            end
            S_TCMP:
            begin
                cmd.trk_cmp = 1'b1;
                state_next  = (st.trk_match || st.trk_last) ? S_TUPD : S_TRD;
            end
            S_TUPD:
            begin
                cmd.trk_upd = 1'b1;
                state_next  = st.relay_on ? S_MOD : S_DONE;
            end
            S_MOD:
            begin
                cmd.mod_en = 1'b1;
                if (st.mod_last)
                begin
                    state_next = S_BRD;
                end
            end
            S_BRD:
            begin
                cmd.bm_rd  = 1'b1;
                state_next = S_BUPD;
            end
            S_BUPD:
            begin
                cmd.bm_upd = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            tick_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

>>> design/mprf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module mprf_dp #(
    parameter int SEQ_TRACKS     = 8,
    parameter int HASH_SIZE      = 1024,
    parameter int MAX_DATA_BYTES = 256
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [7:0]       data_byte,
    input  wire mprf_pkg::cfg_t   cfg,
    input  wire mprf_pkg::cmd_t   cmd,
    output mprf_pkg::status_t     st,
    output mprf_pkg::result_t     out_res
);
    localparam int POS_LIM = mprf_pkg::HDR_BYTES + MAX_DATA_BYTES;
    localparam int POS_W   = $clog2(POS_LIM + 1);
    localparam int TRK_W   = (SEQ_TRACKS > 1) ? $clog2(SEQ_TRACKS) : 1;
    localparam int HASH_W  = $clog2(HASH_SIZE);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(HASH_SIZE));

    logic [15:0]       crc_reg, crc_next;
    logic [31:0]       hash_reg, hash_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [47:0]       hdr_reg, hdr_next;
    logic [15:0]       rcrc_reg, rcrc_next;
    logic              short_reg;
    mprf_pkg::result_t res_reg, out_reg;
    mprf_pkg::result_t res_start, res_tick;

    logic [SEQ_TRACKS-1:0] valid_reg;
    logic [39:0]           trk_topic_mem [SEQ_TRACKS];
    logic [7:0]            trk_seq_mem [SEQ_TRACKS];
    logic [39:0]           trk_topic_q;
    logic [7:0]            trk_seq_q;
    logic [TRK_W-1:0]      idx_reg, free_reg, evict_reg, slot;
    logic                  hit_reg, free_found_reg;

    logic                  bm_mem [HASH_SIZE];
    logic                  bm_q;
    logic [HASH_W-1:0]     clr_cnt_reg, rem_reg, bm_addr;
    logic [31:0]           shr_reg;
    logic [31:0]           q_reg;
    logic [63:0]           qprod;
    logic [31:0]           rdiff;
    logic                  mod_cnt_reg;
    logic [8:0]            dup_cnt_reg;
    logic                  bm_we, bm_wd;

    logic              first;
    logic [15:0]       crc_base;
    logic [31:0]       hash_base;
    logic [47:0]       hdr_base;
    logic [15:0]       rcrc_base;
    logic [POS_W-1:0]  pos_cnt, plen_full;
    logic [39:0]       topic, mask;
    logic [7:0]        seq;
    logic              help_hit;

    assign first     = (pos_reg == '0);
    assign crc_base  = first ? mprf_pkg::CRC_INIT : crc_reg;
    assign hash_base = first ? (mprf_pkg::FNV_BASIS ^ cfg.hash_salt) : hash_reg;
    assign hdr_base  = first ? '0 : hdr_reg;
    assign rcrc_base = first ? '0 : rcrc_reg;
    assign pos_cnt   = (pos_reg < POS_W'(POS_LIM)) ? pos_reg + 1'b1 : pos_reg;
    assign plen_full = pos_cnt - POS_W'(mprf_pkg::CRC_END);

    always_comb
    begin
        crc_next  = crc_base;
        hash_next = hash_base;
        hdr_next  = hdr_base;
        rcrc_next = rcrc_base;
        if (pos_reg < POS_W'(mprf_pkg::HDR_BYTES))
        begin
            hdr_next  = {hdr_base[39:0], data_byte};
            crc_next  = mprf_pkg::crc_byte(crc_base, data_byte);
            hash_next = mprf_pkg::hash_byte(hash_base, data_byte);
        end
        else if (pos_reg < POS_W'(mprf_pkg::CRC_END))
        begin
            rcrc_next = {rcrc_base[7:0], data_byte};
            hash_next = mprf_pkg::hash_byte(hash_base, data_byte);
        end
        else if (pos_reg < POS_W'(POS_LIM))
        begin
            crc_next = mprf_pkg::crc_byte(crc_base, data_byte);
            if (pos_reg < POS_W'(mprf_pkg::HASH_END))
            begin
                hash_next = mprf_pkg::hash_byte(hash_base, data_byte);
            end
        end
        pos_next = cmd.take_last ? '0 : pos_cnt;
    end

    always_comb
    begin
        res_start = '0;
        if (pos_cnt >= POS_W'(mprf_pkg::CRC_END))
        begin
            res_start.topic       = hdr_next[47:8];
            res_start.payload_len = (plen_full > POS_W'(mprf_pkg::LEN_MAX)) ?
                                    mprf_pkg::LEN_MAX : plen_full[7:0];
        end
    end

    always_comb
    begin
        res_tick              = '0;
        res_tick.kind         = mprf_pkg::KIND_CLEAR;
        res_tick.dup_overflow = dup_cnt_reg[8];
    end

    assign topic = hdr_reg[47:8];
    assign seq   = hdr_reg[7:0];

    always_comb
    begin
        mask = '0;
        if (cfg.network_bits != '0 && cfg.network_bits <= mprf_pkg::NET_BITS_MAX)
        begin
            mask = ~({40{1'b1}} >> cfg.network_bits);
        end
    end

    assign help_hit = (topic == cfg.help_topic);

    always_comb
    begin
        st.is_short  = short_reg;
        st.crc_ok    = (rcrc_reg == crc_reg);
        st.help      = help_hit;
        st.foreign   = !help_hit && (mask != '0) &&
                       ((topic & mask) != (cfg.network_id & mask));
        st.relay_on  = cfg.rebroadcast;
        st.trk_match = valid_reg[idx_reg] && (trk_topic_q == topic);
        st.trk_last  = (idx_reg == TRK_W'(SEQ_TRACKS - 1));
        st.mod_last  = mod_cnt_reg;
        st.clr_last  = (clr_cnt_reg == HASH_W'(HASH_SIZE - 1));
    end

    assign slot  = free_found_reg ? free_reg : evict_reg;

    // The reciprocal estimate of the quotient is low by at most one, so a single
    // conditional subtraction yields the exact remainder.
    assign qprod = 64'(shr_reg) * 64'(RECIP);
    assign rdiff = shr_reg - 32'(q_reg * 32'(HASH_SIZE));

    always_ff @(posedge clk)
    begin
        if (cmd.take_byte)
        begin
            crc_reg  <= crc_next;
            hash_reg <= hash_next;
            hdr_reg  <= hdr_next;
            rcrc_reg <= rcrc_next;
        end
        if (cmd.trk_rd)
        begin
            trk_topic_q <= trk_topic_mem[idx_reg];
            trk_seq_q   <= trk_seq_mem[idx_reg];
        end
        if (cmd.trk_upd)
        begin
            if (hit_reg)
            begin
                trk_seq_mem[idx_reg] <= seq;
            end
            else
            begin
                trk_topic_mem[slot] <= topic;
                trk_seq_mem[slot]   <= seq;
            end
        end
        if (cmd.chk_en)
        begin
            shr_reg <= hash_reg;
        end
        if (cmd.mod_en && !mod_cnt_reg)
        begin
            q_reg <= qprod[63:32];
        end
        if (cmd.load_out)
        begin
            out_reg <= res_reg;
        end
    end

    assign bm_we   = cmd.clr_en || (cmd.bm_upd && !bm_q);
    assign bm_wd   = !cmd.clr_en;
    assign bm_addr = cmd.clr_en ? clr_cnt_reg : rem_reg;

    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bm_mem[bm_addr] <= bm_wd;
        end
        if (cmd.bm_rd)
        begin
            bm_q <= bm_mem[rem_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            short_reg      <= 1'b0;
            res_reg        <= '0;
            valid_reg      <= '0;
            idx_reg        <= '0;
            free_reg       <= '0;
            evict_reg      <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            clr_cnt_reg    <= '0;
            rem_reg        <= '0;
            mod_cnt_reg    <= 1'b0;
            dup_cnt_reg    <= '0;
        end
        else
        begin
            if (cmd.take_byte)
            begin
                pos_reg <= pos_next;
            end
            if (cmd.take_last)
            begin
                short_reg <= (pos_cnt < POS_W'(mprf_pkg::CRC_END));
                res_reg   <= res_start;
            end
            if (cmd.take_tick)
            begin
                res_reg     <= res_tick;
                dup_cnt_reg <= '0;
            end
            if (cmd.clr_en)
            begin
                clr_cnt_reg <= st.clr_last ? '0 : clr_cnt_reg + 1'b1;
            end
            if (cmd.chk_en)
            begin
                if (!st.crc_ok)
                begin
                    res_reg.kind <= mprf_pkg::KIND_BAD_CRC;
                end
                else if (st.foreign)
                begin
                    res_reg.kind <= mprf_pkg::KIND_FOREIGN;
                end
                else
                begin
                    res_reg.kind <= mprf_pkg::KIND_ACCEPT;
                end
                idx_reg        <= '0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
                rem_reg        <= '0;
                mod_cnt_reg    <= 1'b0;
            end
            if (cmd.trk_cmp)
            begin
                if (st.trk_match)
                begin
                    hit_reg <= 1'b1;
                end
                else
                begin
                    if (!valid_reg[idx_reg] && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_reg       <= idx_reg;
                    end
                    if (!st.trk_last)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
            end
            if (cmd.trk_upd)
            begin
                if (hit_reg)
                begin
                    res_reg.seq_gap <= seq - trk_seq_q - 8'd1;
                end
                else
                begin
                    valid_reg[slot] <= 1'b1;
                    if (!free_found_reg)
                    begin
                        evict_reg <= (evict_reg == TRK_W'(SEQ_TRACKS - 1)) ?
                                     '0 : evict_reg + 1'b1;
                    end
                end
            end
            if (cmd.mod_en)
            begin
                if (mod_cnt_reg)
                begin
                    rem_reg <= (rdiff >= 32'(HASH_SIZE)) ?
                               HASH_W'(rdiff - 32'(HASH_SIZE)) : HASH_W'(rdiff);
                end
                mod_cnt_reg <= !mod_cnt_reg;
            end
            if (cmd.bm_upd)
            begin
                if (bm_q)
                begin
                    res_reg.duplicate <= 1'b1;
                    if (!dup_cnt_reg[8])
                    begin
                        dup_cnt_reg <= dup_cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    res_reg.relay <= 1'b1;
                end
            end
        end
    end

    assign out_res = out_reg;
endmodule
`default_nettype wire

>>> dv/mprf_tb_intf.sv
`timescale 1ns / 1ps
// The channel interfaces are defined with the design; this file only provides
// a helper type used by the bench.
package mprf_tb_pkg;
    typedef struct {
        logic        cmd;
        logic [7:0]  data_byte;
        logic        last_byte;
    } rx_byte_t;
endpackage

>>> dv/tb_mesh_packet_rx_filter.sv
`timescale 1ns / 1ps
module tb_mesh_packet_rx_filter;

    localparam int TRACKS = 8;
    localparam int BITMAP = 1024;
    localparam int MAXDATA = 256;
    localparam int WATCHDOG = 20000;
    localparam int TOTAL_ITEMS = 850;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [mprf_pkg::ADDR_W-1:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;

    mprf_in_if in_ch ();
    mprf_out_if out_ch ();

    mesh_packet_rx_filter i_dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    class verdict_board;
        mprf_pkg::result_t pending[$];
        int errors;
        int checked;
        int kinds[5];
        mprf_pkg::cfg_t cfg;
        logic [15:0] crc;
        logic [31:0] hsh;
        int pos;
        logic [47:0] hdr;
        logic [15:0] rcrc;
        bit tvalid[TRACKS];
        logic [39:0] ttopic[TRACKS];
        logic [7:0] tseq[TRACKS];
        int evict;
        bit seen[BITMAP];
        int dups;

        function new();
            cfg = '0;
            errors = 0;
            checked = 0;
            evict = 0;
            dups = 0;
            pos = 0;
            foreach (kinds[i]) kinds[i] = 0;
            foreach (tvalid[i]) tvalid[i] = 0;
            foreach (seen[i]) seen[i] = 0;
            restart();
        endfunction

        function void restart();
            crc = 16'hFFFF;
            hsh = mprf_pkg::FNV_BASIS ^ cfg.hash_salt;
            pos = 0;
            hdr = '0;
            rcrc = '0;
        endfunction

        function void emit(mprf_pkg::result_t r);
            pending.push_back(r);
            kinds[r.kind]++;
        endfunction

        function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
            c = c ^ {b, 8'h00};
            for (int i = 0; i < 8; i++) c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : (c << 1);
            return c;
        endfunction

        function logic [31:0] fnv_step(logic [31:0] h, logic [7:0] b);
            logic [63:0] p;
            p = 64'(h ^ {24'd0, b}) * 64'd16777619;
            return p[31:0];
        endfunction

        function logic [7:0] track(logic [39:0] t, logic [7:0] s);
            int slot;
            logic [7:0] g;
            for (int i = 0; i < TRACKS; i++)
                if (tvalid[i] && ttopic[i] == t)
                begin
                    g = s - tseq[i] - 8'd1;
                    tseq[i] = s;
                    return g;
                end
            slot = -1;
            for (int i = 0; i < TRACKS; i++)
                if (!tvalid[i] && slot < 0) slot = i;
            if (slot < 0)
            begin
                slot = evict;
                evict = (evict + 1) % TRACKS;
            end
            tvalid[slot] = 1;
            ttopic[slot] = t;
            tseq[slot] = s;
            return 8'd0;
        endfunction

        function void note_input(mprf_tb_pkg::rx_byte_t x);
            mprf_pkg::result_t r;
            int cnt;
            logic [39:0] t, m;
            int idx;
            r = '0;
            if (x.cmd)
            begin
                r.kind = mprf_pkg::KIND_CLEAR;
                r.dup_overflow = dups > 255;
                dups = 0;
                foreach (seen[i]) seen[i] = 0;
                emit(r);
                return;
            end
            if (pos == 0) restart();
            if (pos < 6)
            begin
                hdr = {hdr[39:0], x.data_byte};
                crc = crc_step(crc, x.data_byte);
                hsh = fnv_step(hsh, x.data_byte);
            end
            else if (pos < 8)
            begin
                rcrc = {rcrc[7:0], x.data_byte};
                hsh = fnv_step(hsh, x.data_byte);
            end
            else if (pos < 6 + MAXDATA)
            begin
                crc = crc_step(crc, x.data_byte);
                if (pos < 10) hsh = fnv_step(hsh, x.data_byte);
            end
            if (pos < 6 + MAXDATA) pos++;
            if (!x.last_byte) return;
            cnt = pos;
            if (cnt < 8)
            begin
                r.kind = mprf_pkg::KIND_SHORT;
                restart();
                emit(r);
                return;
            end
            t = hdr[47:8];
            r.topic = t;
            r.payload_len = (cnt - 8 > 255) ? 8'd255 : 8'(cnt - 8);
            if (rcrc != crc) r.kind = mprf_pkg::KIND_BAD_CRC;
            else
            begin
                m = '0;
                if (cfg.network_bits >= 1 && cfg.network_bits <= 40)
                    m = ((40'd1 << cfg.network_bits) - 40'd1) << (40 - cfg.network_bits);
                if (t != cfg.help_topic && m != 0 && (t & m) != (cfg.network_id & m))
                    r.kind = mprf_pkg::KIND_FOREIGN;
                else
                begin
                    r.kind = mprf_pkg::KIND_ACCEPT;
                    if (t != cfg.help_topic) r.seq_gap = track(t, hdr[7:0]);
                    if (cfg.rebroadcast)
                    begin
                        idx = hsh % BITMAP;
                        if (seen[idx])
                        begin
                            r.duplicate = 1;
                            if (dups < 256) dups++;
                        end
                        else
                        begin
                            seen[idx] = 1;
                            r.relay = 1;
                        end
                    end
                end
            end
            restart();
            emit(r);
        endfunction

        function void check_result(mprf_pkg::result_t got);
            mprf_pkg::result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got !== e)
            begin
                $display("%0t: mismatch expected %p actual %p", $time, e, got);
                errors++;
            end
        endfunction
    endclass

    verdict_board board = new();
    int idle_cycles = 0;
    int stall_mode = 0;
    int sent = 0;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.cmd = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        out_ch.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        mprf_pkg::result_t r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            r.kind = out_ch.kind;
            r.topic = out_ch.topic;
            r.payload_len = out_ch.payload_len;
            r.seq_gap = out_ch.seq_gap;
            r.relay = out_ch.relay;
            r.duplicate = out_ch.duplicate;
            r.dup_overflow = out_ch.dup_overflow;
            board.check_result(r);
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("Timeout with %0d results outstanding", board.pending.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= mprf_pkg::ADDR_W'({idx, 3'b000});
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            mprf_pkg::REG_HASH_SALT: board.cfg.hash_salt = val[31:0];
            mprf_pkg::REG_NETWORK_ID: board.cfg.network_id = val[39:0];
            mprf_pkg::REG_NETWORK_BITS: board.cfg.network_bits = val[5:0];
            mprf_pkg::REG_HELP_TOPIC: board.cfg.help_topic = val[39:0];
            default: board.cfg.rebroadcast = val[0];
        endcase
    endtask

    task automatic send_item(input logic cmd, input logic [7:0] b, input logic last);
        mprf_tb_pkg::rx_byte_t x;
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.cmd <= cmd;
        in_ch.data_byte <= b;
        in_ch.last_byte <= last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        x.cmd = cmd;
        x.data_byte = b;
        x.last_byte = last;
        board.note_input(x);
        sent++;
        if ($urandom_range(0, 7) == 0)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    task automatic send_packet(input logic [39:0] topic, input logic [7:0] seq,
                               input int plen, input bit good_crc);
        logic [7:0] bytes[$];
        logic [15:0] c;
        c = 16'hFFFF;
        for (int i = 4; i >= 0; i--) bytes.push_back(topic[8*i +: 8]);
        bytes.push_back(seq);
        foreach (bytes[i]) c = board.crc_step(c, bytes[i]);
        for (int i = 0; i < plen; i++)
        begin
            bytes.push_back(8'($urandom));
            if (i < MAXDATA - 2) c = board.crc_step(c, bytes[bytes.size() - 1]);
        end
        if (!good_crc) c = c ^ 16'(1 << $urandom_range(0, 15));
        bytes.insert(6, c[15:8]);
        bytes.insert(7, c[7:0]);
        foreach (bytes[i]) send_item(1'b0, bytes[i], i == bytes.size() - 1);
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (board.pending.size() > 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    logic [39:0] topics[16];

    initial
    begin
        int k;
        int ph;
        int base;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (topics[i]) topics[i] = {$urandom, 8'($urandom)};
        topics[0] = 40'hFF_FFFF_FFFF;
        topics[1] = 40'h0;

        // Directed part.
        write_reg(mprf_pkg::REG_REBROADCAST, 64'd1);
        write_reg(mprf_pkg::REG_HELP_TOPIC, {24'd0, topics[2]});
        send_item(1'b0, 8'hFF, 1'b1);
        for (int i = 0; i < 7; i++) send_item(1'b0, 8'h00, i == 6);
        send_packet(topics[0], 8'hFF, 0, 1);
        send_packet(topics[0], 8'h01, 4, 1);
        send_packet(topics[0], 8'h01, 4, 0);
        send_packet(topics[1], 8'h00, 260, 1);
        send_packet(topics[2], 8'h10, 2, 1);
        send_packet(topics[2], 8'h20, 2, 1);
        send_item(1'b1, 8'hAA, 1'b1);
        for (int i = 0; i < 10; i++) send_packet(topics[3 + i], 8'(i), 1, 1);
        send_item(1'b0, 8'h55, 1'b0);
        send_item(1'b1, 8'h00, 1'b0);
        for (int i = 0; i < 8; i++) send_item(1'b0, 8'h12, i == 7);
        drain();
        // Repeated copies of one packet are flagged as duplicates.
        write_reg(mprf_pkg::REG_HASH_SALT, 64'hFFFF_FFFF);
        for (int i = 0; i < 4; i++) send_packet(topics[0], 8'h07, 0, 1);
        send_item(1'b1, 8'h00, 1'b0);
        drain();

        base = sent;
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(mprf_pkg::REG_NETWORK_BITS, 64'd40);
                    write_reg(mprf_pkg::REG_NETWORK_ID, {24'd0, topics[5]});
                    write_reg(mprf_pkg::REG_REBROADCAST, 64'd0);
                end
                1:
                begin
                    write_reg(mprf_pkg::REG_NETWORK_BITS, 64'd8);
                    write_reg(mprf_pkg::REG_NETWORK_ID, {24'd0, topics[6][39:32], 32'd0});
                    write_reg(mprf_pkg::REG_HASH_SALT, 64'($urandom));
                    write_reg(mprf_pkg::REG_REBROADCAST, 64'd1);
                end
                2:
                begin
                    write_reg(mprf_pkg::REG_NETWORK_BITS, 64'd63);
                    write_reg(mprf_pkg::REG_HELP_TOPIC, 64'h0);
                end
                default:
                begin
                    write_reg(mprf_pkg::REG_NETWORK_BITS, 64'd1);
                    write_reg(mprf_pkg::REG_NETWORK_ID, 64'hFF_FFFF_FFFF);
                    write_reg(mprf_pkg::REG_HASH_SALT, 64'h0);
                end
            endcase
            while (sent < base + (TOTAL_ITEMS - base) * (ph + 1) / 4)
            begin
                k = $urandom_range(0, 19);
                if (k == 0)
                begin
                    send_item(1'b1, 8'($urandom), 1'($urandom));
                end
                else if (k == 1)
                begin
                    int n;
                    n = $urandom_range(1, 9);
                    for (int i = 0; i < n; i++) send_item(1'b0, 8'($urandom), i == n - 1);
                end
                else
                begin
                    int pl;
                    pl = ($urandom_range(0, 30) == 0) ? $urandom_range(200, 280)
                                                     : $urandom_range(0, 6);
                    if (ph == 1 && $urandom_range(0, 1))
                        topics[$urandom_range(0, 15)][39:32] = topics[6][39:32];
                    send_packet(topics[$urandom_range(0, 15)],
                                8'($urandom_range(0, 3) == 0 ? $urandom : sent),
                                pl, $urandom_range(0, 9) != 0);
                end
            end
            drain();
        end

        $display("Checked %0d results from %0d items: %0d accepted, %0d bad CRC, %0d foreign.",
                 board.checked, sent, board.kinds[3], board.kinds[1], board.kinds[2]);
        $display("Also %0d short packets and %0d clear ticks over four filter setups.",
                 board.kinds[0], board.kinds[4]);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

>>> sim.f
design/mprf_pkg.sv
design/mprf_intf.sv
design/mprf_regs.sv
design/mprf_ctrl.sv
design/mprf_dp.sv
design/mesh_packet_rx_filter.sv
dv/mprf_tb_intf.sv
dv/tb_mesh_packet_rx_filter.sv
